// ----- rtl/surt_pkg.sv -----
`default_nettype none

package surt_pkg;

    // design defaults
    localparam int PAYLOAD_MAX_DEF = 32;
    localparam int PAYLOAD_CAP_MAX = 31;
    localparam int FILL_MAX        = 35;
    localparam int FILL_W          = 6;
    localparam logic [3:0] MAX_ROUNDS_RST = 4'd5;

    // input operations
    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_READ    = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_RX_BYTE = 3'd3;
    localparam logic [2:0] OP_TIMEOUT = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // frame and reply bytes
    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] DIR_READ    = 8'h01;
    localparam logic [7:0] DIR_WRITE   = 8'h00;
    localparam logic [7:0] READ_HDR    = 8'hBB;
    localparam logic [7:0] STATUS_HDR  = 8'hEE;
    localparam logic [7:0] CODE_OK     = 8'h01;
    localparam logic [7:0] CODE_RD_ERR = 8'h02;
    localparam logic [7:0] CODE_BADADR = 8'h03;
    localparam logic [7:0] CODE_OVRRUN = 8'h06;
    localparam logic [7:0] CODE_MAXLEN = 8'h07;
    localparam logic [7:0] CODE_CHARTO = 8'h0A;

    // final status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_UNKNOWN      = 4'd10;
    localparam logic [3:0] ST_UART_TIMEOUT = 4'd11;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_JUDGE, S_SYNC, S_DIR, S_REG, S_LEN, S_PAY, S_DATA, S_FILL, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        BSEL_SYNC, BSEL_DIR, BSEL_REG, BSEL_LEN, BSEL_PAY, BSEL_CODE, BSEL_ZERO
    } t_bsel;

    typedef enum logic [1:0] {
        DST_OK, DST_MAP, DST_TIMEOUT
    } t_dst;

    // controller to datapath
    typedef struct packed {
        logic  latch;
        logic  load_pay;
        logic  start;
        logic  finish;
        logic  store_hdr;
        logic  set_hc2;
        logic  retry;
        logic  bump_seen;
        logic  load_fill;
        logic  dec_fill;
        logic  st_load;
        t_dst  st_sel;
        logic  emit;
        logic [1:0] kind;
        t_bsel bsel;
        logic  last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       busy;
        logic [1:0] hc;
        logic       hdr_bb;
        logic       hdr_ee;
        logic       is_write;
        logic       retry_ok;
        logic       round_lt_max;
        logic       code_ok;
        logic       len_zero;
        logic       data_end;
        logic       pay_full;
        logic       pay_empty;
        logic       pay_last;
        logic       fill_zero;
        logic       out_free;
    } t_stat;

    // sensor status code to final status
    function automatic logic [3:0] map_code(input logic [7:0] code);
        logic [3:0] res;
        res = ST_UNKNOWN;
        if (code >= 8'h02 && code <= 8'h0A) begin
            res = 4'(code - 8'd1);
        end
        return res;
    endfunction

    function automatic logic retryable(input logic [7:0] code, input logic wr);
        logic res;
        if (wr) begin
            res = (code == CODE_MAXLEN) || (code == CODE_BADADR) ||
                  (code == CODE_OVRRUN) || (code == CODE_CHARTO);
        end else begin
            res = (code == CODE_MAXLEN) || (code == CODE_RD_ERR) || (code == CODE_CHARTO);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/surt_ctrl.sv -----
`default_nettype none

module surt_ctrl
    import surt_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_in_valid,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.st_sel = DST_OK;
        o_cmd.bsel   = BSEL_ZERO;
        o_cmd.kind   = KIND_TX;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_stat.op)
                    OP_LOAD: begin
                        if (!i_stat.busy && !i_stat.pay_full) begin
                            o_cmd.load_pay = 1'b1;
                        end
                    end
                    OP_READ, OP_WRITE: begin
                        if (!i_stat.busy) begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SYNC;
                        end
                    end
                    OP_RX_BYTE: begin
                        if (i_stat.busy) begin
                            if (i_stat.hc == 2'd0) begin
                                o_cmd.store_hdr = 1'b1;
                            end else if (i_stat.hc == 2'd1) begin
                                o_cmd.set_hc2 = 1'b1;
                                if (i_stat.is_write || !i_stat.hdr_bb) begin
                                    n_state = S_JUDGE;
                                end else if (i_stat.len_zero) begin
                                    o_cmd.st_load = 1'b1;
                                    o_cmd.st_sel  = DST_OK;
                                    n_state       = S_DONE;
                                end
                            end else begin
                                n_state = S_DATA;
                            end
                        end
                    end
                    OP_TIMEOUT: begin
                        if (i_stat.busy) begin
                            if (i_stat.hc == 2'd0) begin
                                o_cmd.st_load = 1'b1;
                                o_cmd.st_sel  = DST_TIMEOUT;
                                n_state       = S_DONE;
                            end else if (i_stat.hc == 2'd1 &&
                                         (i_stat.is_write || !i_stat.hdr_bb)) begin
                                n_state = S_JUDGE;
                            end else begin
                                o_cmd.load_fill = 1'b1;
                                o_cmd.st_load   = 1'b1;
                                o_cmd.st_sel    = DST_OK;
                                n_state         = S_FILL;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_JUDGE: begin
                o_cmd.st_load = 1'b1;
                n_state       = S_DONE;
                if (i_stat.hdr_ee && i_stat.retry_ok) begin
                    if (i_stat.round_lt_max) begin
                        o_cmd.st_load = 1'b0;
                        o_cmd.retry   = 1'b1;
                        n_state       = S_SYNC;
                    end else begin
                        o_cmd.st_sel = DST_MAP;
                    end
                end else if (i_stat.hdr_ee && i_stat.is_write && i_stat.code_ok) begin
                    o_cmd.st_sel = DST_OK;
                end else begin
                    o_cmd.st_sel = DST_MAP;
                end
            end
            // command frame, one byte per free output slot
            S_SYNC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.bsel = BSEL_SYNC;
                    n_state    = S_DIR;
                end
            end
            S_DIR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.bsel = BSEL_DIR;
                    n_state    = S_REG;
                end
            end
            S_REG: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.bsel = BSEL_REG;
                    n_state    = S_LEN;
                end
            end
            S_LEN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.bsel = BSEL_LEN;
                    if (i_stat.is_write && !i_stat.pay_empty) begin
                        n_state = S_PAY;
                    end else if (i_stat.busy) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_sel  = DST_OK;
                        n_state       = S_DONE;
                    end
                end
            end
            S_PAY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.bsel = BSEL_PAY;
                    if (i_stat.pay_last) begin
                        if (i_stat.busy) begin
                            o_cmd.last = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st_sel  = DST_OK;
                            n_state       = S_DONE;
                        end
                    end
                end
            end
            // one received data byte passed on
            S_DATA: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = KIND_DATA;
                    o_cmd.bsel      = BSEL_CODE;
                    o_cmd.bump_seen = 1'b1;
                    if (i_stat.data_end) begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st_sel  = DST_OK;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            // zeros for missing read bytes
            S_FILL: begin
                if (i_stat.fill_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = KIND_DATA;
                    o_cmd.bsel     = BSEL_ZERO;
                    o_cmd.dec_fill = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = KIND_DONE;
                    o_cmd.bsel   = BSEL_ZERO;
                    o_cmd.last   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/surt_dp.sv -----
`default_nettype none

module surt_dp
    import surt_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [3:0]  i_cfg_data,
    input  wire  [2:0]  i_op,
    input  wire  [7:0]  i_reg_addr,
    input  wire  [7:0]  i_length,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_expect_ack,
    input  wire         i_out_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [3:0]  o_status,
    output logic        o_last
);

    localparam int CAP   = (PAYLOAD_MAX < PAYLOAD_CAP_MAX) ? PAYLOAD_MAX : PAYLOAD_CAP_MAX;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    // latched input item
    logic [2:0]       r_op;
    logic [7:0]       r_reg_in;
    logic [7:0]       r_len_in;
    logic [7:0]       r_code;
    logic             r_ack;

    // transaction state
    logic [3:0]       r_max;
    logic             r_busy;
    logic             r_is_write;
    logic [7:0]       r_saved_reg;
    logic [7:0]       r_saved_len;
    logic [3:0]       r_round;
    logic [CNT_W-1:0] r_pay_cnt;
    logic [CNT_W-1:0] r_pay_idx;
    logic [CNT_W-1:0] n_pay_idx;
    logic [7:0]       r_seen;
    logic [7:0]       r_hdr;
    logic [1:0]       r_hc;
    logic [FILL_W-1:0] r_fill;
    logic [3:0]       r_done_st;

    logic [7:0]       r_mem [PAYLOAD_MAX];
    logic [7:0]       r_rd_data;

    logic [7:0]       w_missing;
    logic [7:0]       w_byte;
    logic             w_out_free;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_ROUNDS_RST;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // input latch, timeout carries a zero status code
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_op;
            r_reg_in <= i_reg_addr;
            r_len_in <= i_length;
            r_code   <= (i_op == OP_TIMEOUT) ? 8'h00 : i_in_byte;
            r_ack    <= i_expect_ack;
        end
    end

    // missing read bytes, capped
    always_comb begin
        w_missing = (r_saved_len > r_seen) ? (r_saved_len - r_seen) : 8'd0;
        if (w_missing > 8'(FILL_MAX)) begin
            w_missing = 8'(FILL_MAX);
        end
    end

    // transaction registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_is_write  <= 1'b0;
            r_saved_reg <= '0;
            r_saved_len <= '0;
            r_round     <= '0;
            r_pay_cnt   <= '0;
            r_seen      <= '0;
            r_hdr       <= '0;
            r_hc        <= '0;
            r_fill      <= '0;
            r_done_st   <= ST_OK;
        end else begin
            if (i_cmd.load_pay) begin
                r_pay_cnt <= r_pay_cnt + 1'b1;
            end
            if (i_cmd.start) begin
                r_busy      <= r_ack;
                r_is_write  <= (r_op == OP_WRITE);
                r_saved_reg <= r_reg_in;
                r_saved_len <= (r_op == OP_WRITE) ? 8'(r_pay_cnt) : r_len_in;
                r_round     <= 4'd1;
                r_hc        <= '0;
                r_hdr       <= '0;
                r_seen      <= '0;
            end
            if (i_cmd.retry) begin
                r_round <= r_round + 4'd1;
                r_hc    <= '0;
                r_hdr   <= '0;
                r_seen  <= '0;
            end
            if (i_cmd.store_hdr) begin
                r_hdr <= r_code;
                r_hc  <= 2'd1;
            end
            if (i_cmd.set_hc2) begin
                r_hc <= 2'd2;
            end
            if (i_cmd.bump_seen) begin
                r_seen <= r_seen + 8'd1;
            end
            if (i_cmd.load_fill) begin
                r_fill <= FILL_W'(w_missing);
            end else if (i_cmd.dec_fill) begin
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.st_load) begin
                unique case (i_cmd.st_sel)
                    DST_OK:      r_done_st <= ST_OK;
                    DST_MAP:     r_done_st <= map_code(r_code);
                    DST_TIMEOUT: r_done_st <= ST_UART_TIMEOUT;
                    default:     r_done_st <= ST_UNKNOWN;
                endcase
            end
            if (i_cmd.finish) begin
                r_busy <= 1'b0;
                if (r_is_write) begin
                    r_pay_cnt <= '0;
                end
            end
        end
    end

    // payload read index, read address runs one step ahead
    always_comb begin
        n_pay_idx = r_pay_idx;
        if (i_cmd.start || i_cmd.retry) begin
            n_pay_idx = '0;
        end else if (i_cmd.emit && i_cmd.bsel == BSEL_PAY) begin
            n_pay_idx = r_pay_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay_idx <= '0;
        end else begin
            r_pay_idx <= n_pay_idx;
        end
    end

    // payload memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pay) begin
            r_mem[IDX_W'(r_pay_cnt)] <= r_code;
        end
        r_rd_data <= r_mem[IDX_W'(n_pay_idx)];
    end

    // result byte select
    always_comb begin
        unique case (i_cmd.bsel)
            BSEL_SYNC: w_byte = SYNC_BYTE;
            BSEL_DIR:  w_byte = r_is_write ? DIR_WRITE : DIR_READ;
            BSEL_REG:  w_byte = r_saved_reg;
            BSEL_LEN:  w_byte = r_saved_len;
            BSEL_PAY:  w_byte = r_rd_data;
            BSEL_CODE: w_byte = r_code;
            default:   w_byte = 8'h00;
        endcase
    end

    // output register
    assign w_out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_kind     <= i_cmd.kind;
            o_out_byte <= w_byte;
            o_status   <= (i_cmd.kind == KIND_DONE) ? r_done_st : ST_OK;
            o_last     <= i_cmd.last;
        end
    end

    // status to controller
    always_comb begin
        o_stat.op           = r_op;
        o_stat.busy         = r_busy;
        o_stat.hc           = r_hc;
        o_stat.hdr_bb       = (r_hdr == READ_HDR);
        o_stat.hdr_ee       = (r_hdr == STATUS_HDR);
        o_stat.is_write     = r_is_write;
        o_stat.retry_ok     = retryable(r_code, r_is_write);
        o_stat.round_lt_max = (r_round < r_max);
        o_stat.code_ok      = (r_code == CODE_OK);
        o_stat.len_zero     = (r_saved_len == 8'd0);
        o_stat.data_end     = ({1'b0, r_seen} + 9'd1) >= {1'b0, r_saved_len};
        o_stat.pay_full     = (r_pay_cnt >= CNT_W'(CAP));
        o_stat.pay_empty    = (r_pay_cnt == '0);
        o_stat.pay_last     = ((r_pay_idx + 1'b1) == r_pay_cnt);
        o_stat.fill_zero    = (r_fill == '0);
        o_stat.out_free     = w_out_free;
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result emitted into a full output register");

    a_pay_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_cnt <= CNT_W'(CAP))
        else $error("payload count beyond capacity");

    a_hc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc != 2'd3)
        else $error("reply header count out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.kind == KIND_DONE) |=> !r_busy)
        else $error("engine still busy after done result");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.kind == KIND_DONE) |=> (o_last && o_out_byte == 8'h00))
        else $error("done result not marked last or carries data");
`endif

endmodule

`default_nettype wire

// ----- rtl/sensor_uart_register_transaction_core.sv -----
`default_nettype none

// Host-side engine for a sensor's UART register protocol. Load write payload
// bytes first (op 0), then start a read (op 1) or write (op 2); the engine
// sends 0xAA, direction, register, length and payload as transmit results,
// then parses received bytes (op 3) and timeouts (op 4) and ends each
// transaction with one done result carrying the final status. Retryable
// sensor errors resend the frame up to max_rounds attempts. Input items are
// taken one at a time: an item is accepted and then decoded, and each result
// it causes passes through the single output register. Back-pressure on the
// output stalls result generation but the register holds the last result
// while the next item is accepted. The configuration port is always ready.
module sensor_uart_register_transaction_core
    import surt_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration: max_rounds
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [3:0]  i_cfg_data,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // reg_addr[7:0], length[15:8], in_byte[23:16],
                                        // expect_ack[24], zero[31:25]
    input  wire  [2:0]  s_axis_tuser,   // op[2:0]
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte[7:0], status[11:8], zero[15:12]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [7:0] w_out_byte;
    logic [3:0] w_status;

    assign o_cfg_ready = 1'b1;

    // sequencer
    surt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // state, payload store and output register
    surt_dp #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_op         (s_axis_tuser),
        .i_reg_addr   (s_axis_tdata[7:0]),
        .i_length     (s_axis_tdata[15:8]),
        .i_in_byte    (s_axis_tdata[23:16]),
        .i_expect_ack (s_axis_tdata[24]),
        .i_out_ready  (m_axis_tready),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_kind       (m_axis_tuser),
        .o_out_byte   (w_out_byte),
        .o_status     (w_status),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'h0, w_status, w_out_byte};

endmodule

`default_nettype wire
